@@ hdl/crc8d_pkg.sv @@
`default_nettype none

package crc8d_pkg;

  // window geometry
  localparam int WindowDepth = 10;
  localparam int PacketLen   = 9;
  localparam int CrcLen      = PacketLen - 1;
  localparam int CountW      = 4;

  // frame markers and crc settings
  localparam logic [7:0] MarkFirst  = 8'hAA;
  localparam logic [7:0] MarkSecond = 8'h55;
  localparam logic [7:0] CrcPoly    = 8'h07;
  localparam logic [7:0] CrcInit    = 8'hFF;

  typedef logic [7:0]        byte_t;
  typedef logic [CountW-1:0] count_t;

  localparam count_t CountFull = count_t'(WindowDepth);

  // one decoded packet
  typedef struct packed {
    logic [31:0]        timestamp;
    logic signed [31:0] sample_value;
    logic [7:0]         received_crc;
    logic               crc_ok;
  } result_t;

  // crc-8 over one byte, msb first
  function automatic byte_t crc8_byte(input byte_t crc_in, input byte_t data);
    byte_t c;
    c = crc_in ^ data;
    for (int b = 0; b < 8; b++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ hdl/crc8d_in_if.sv @@
`default_nettype none

interface crc8d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       new_request;

  modport source (output valid, output rx_byte, output new_request, input ready);
  modport sink (input valid, input rx_byte, input new_request, output ready);
endinterface

`default_nettype wire

@@ hdl/crc8d_out_if.sv @@
`default_nettype none

interface crc8d_out_if;
  logic               valid;
  logic               ready;
  logic [31:0]        timestamp;
  logic signed [31:0] sample_value;
  logic [7:0]         received_crc;
  logic               crc_ok;

  modport source (output valid, output timestamp, output sample_value,
                  output received_crc, output crc_ok, input ready);
  modport sink (input valid, input timestamp, input sample_value,
                input received_crc, input crc_ok, output ready);
endinterface

`default_nettype wire

@@ hdl/crc8d_window.sv @@
`default_nettype none

module crc8d_window
  import crc8d_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    accept,
  input  wire byte_t   rx_byte,
  input  wire logic    new_request,
  output logic         res_valid,
  output result_t      res
);

  byte_t  window_r  [WindowDepth];
  byte_t  window_nxt[WindowDepth];
  byte_t  part_r    [CrcLen];
  byte_t  part_nxt  [CrcLen];
  byte_t  crc_d1_r;
  byte_t  crc_d2_r;
  count_t count_r;
  count_t count_nxt;
  count_t base_count;
  logic   is_frame;

  // byte history shifts toward entry 0
  always_comb begin
    for (int i = 0; i < WindowDepth - 1; i++) begin
      window_nxt[i] = window_r[i + 1];
    end
    window_nxt[WindowDepth-1] = rx_byte;
  end

  // running crc lanes: lane j covers the newest j+1 bytes
  always_comb begin
    part_nxt[0] = crc8_byte(CrcInit, rx_byte);
    for (int j = 1; j < CrcLen; j++) begin
      part_nxt[j] = crc8_byte(part_r[j-1], rx_byte);
    end
  end

  // saturating byte count, cleared by a start flag
  always_comb begin
    base_count = new_request ? '0 : count_r;
    count_nxt  = (base_count < CountFull) ? base_count + count_t'(1) : base_count;
  end

  // frame detect and packet fields
  always_comb begin
    is_frame  = !new_request && (count_r == CountFull) &&
                (window_r[WindowDepth-1] == MarkFirst) && (rx_byte == MarkSecond);
    res_valid = accept && is_frame;
    res.timestamp    = {window_r[3], window_r[2], window_r[1], window_r[0]};
    res.sample_value = {window_r[7], window_r[6], window_r[5], window_r[4]};
    res.received_crc = window_r[PacketLen-1];
    res.crc_ok       = (crc_d2_r == window_r[PacketLen-1]);
  end

  // payload state, refreshed on every item
  always_ff @(posedge clk) begin
    if (accept) begin
      window_r <= window_nxt;
      part_r   <= part_nxt;
      crc_d1_r <= part_r[CrcLen-1];
      crc_d2_r <= crc_d1_r;
    end
  end

  // count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (accept) begin
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hdl/crc8d_out_buf.sv @@
`default_nettype none

module crc8d_out_buf
  import crc8d_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire result_t push_data,
  output logic         push_ready,
  output logic         out_valid,
  output result_t      out_data,
  input  wire logic    out_ready
);

  logic    out_valid_r;
  logic    out_valid_nxt;
  result_t out_data_r;
  result_t out_data_nxt;
  logic    skid_valid_r;
  logic    skid_valid_nxt;
  result_t skid_data_r;
  result_t skid_data_nxt;
  logic    slot_free;

  assign slot_free  = !out_valid_r || out_ready;
  assign push_ready = !skid_valid_r;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  // output register with one skid entry behind it
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (slot_free) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = push;
        skid_data_nxt  = push_data;
      end else begin
        out_valid_nxt  = push;
        out_data_nxt   = push_data;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = push_data;
    end
  end

  // control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

endmodule

`default_nettype wire

@@ hdl/crc8_trailer_packet_deframer.sv @@
// Packet deframer for a received byte stream with a CRC-8 trailer.
// in_ch carries one received byte per item (rx_byte) and a start flag
// (new_request) that drops all byte history before that byte is taken.
// A packet is nine bytes (timestamp, sample, crc) followed by the marker
// bytes AA then 55; the item carrying the 55 produces one result on out_ch
// with the little-endian timestamp and sample, the received crc byte and
// crc_ok, which is set when CRC-8 (poly 07, init FF) over the first eight
// packet bytes matches. Items that do not close a packet produce nothing.
// A result is registered in the output register, or in the skid entry.
// Throughput: one item per cycle while in_ch is ready; the window shift,
// the eight running crc lanes and the frame compare are combinational.
// Stall: a one-entry skid behind the output register keeps in_ch ready
// while one result waits; in_ch.ready drops only when both hold a result.
// Reset: byte count and output flags clear, so no packet can complete
// before eleven bytes have been received.
`default_nettype none

module crc8_trailer_packet_deframer
  import crc8d_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  crc8d_in_if.sink     in_ch,
  crc8d_out_if.source  out_ch
);

  logic    accept;
  logic    res_valid;
  result_t res;
  logic    buf_ready;
  logic    out_valid;
  result_t out_data;

  assign in_ch.ready = buf_ready;
  assign accept      = in_ch.valid && buf_ready;

  // byte window, crc lanes and frame detect
  crc8d_window u_window (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .rx_byte     (in_ch.rx_byte),
    .new_request (in_ch.new_request),
    .res_valid   (res_valid),
    .res         (res)
  );

  // result register and skid
  crc8d_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_valid),
    .push_data  (res),
    .push_ready (buf_ready),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .out_ready  (out_ch.ready)
  );

  // result channel
  assign out_ch.valid        = out_valid;
  assign out_ch.timestamp    = out_data.timestamp;
  assign out_ch.sample_value = out_data.sample_value;
  assign out_ch.received_crc = out_data.received_crc;
  assign out_ch.crc_ok       = out_data.crc_ok;

`ifndef NO_ASSERTIONS
  // a start flag never closes a packet on the same byte
  a_no_frame_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !in_ch.new_request)
    else $error("packet detected on a start-flag byte");

  // results come only from accepted items
  a_frame_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (in_ch.valid && in_ch.ready))
    else $error("packet detected without an accepted item");

  // input stalls only when a result is waiting at the output
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_ch.valid)
    else $error("input stalled with an empty output");

  // the output is valid in the cycle after a packet is detected
  a_frame_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> out_ch.valid)
    else $error("detected packet did not reach the output");
`endif

endmodule

`default_nettype wire
